[design/ssbr_pkg.sv]
// shared constants and types for the supersample box resolve block
package ssbr_pkg;

    localparam int CHAN_W     = 8;
    localparam int COORD_W    = 10;
    localparam int FACTOR_W   = 4;
    localparam int SIZE_W     = 11;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 11;
    localparam int NUM_LANES  = 4;

    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_MAX_HEIGHT = 1024;
    localparam int DEF_MAX_FACTOR = 8;

    localparam logic [FACTOR_W-1:0] FACTOR_RST = 4'd1;
    localparam logic [SIZE_W-1:0]   SIZE_RST   = 11'd1024;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FACTOR = 2'd0,
        CFG_WIDTH  = 2'd1,
        CFG_HEIGHT = 2'd2
    } cfg_idx_t;

    typedef struct packed {
        logic first;
        logic emit;
        logic row_end;
        logic frame_end;
    } seq_flags_t;

    typedef struct packed {
        logic adv;
        logic rd;
        logic wr;
        logic first;
    } lane_ctl_t;

    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic               row_end;
        logic               frame_end;
    } meta_t;

endpackage

[design/ssbr_if.sv]
// valid/ready channel interfaces for supersampled input and resolved output
interface ssbr_in_if;
    import ssbr_pkg::*;

    logic              valid;
    logic              ready;
    logic [CHAN_W-1:0] in_red;
    logic [CHAN_W-1:0] in_green;
    logic [CHAN_W-1:0] in_blue;
    logic [CHAN_W-1:0] in_alpha;

    modport source (output valid, output in_red, output in_green, output in_blue,
                    output in_alpha, input ready);
    modport sink (input valid, input in_red, input in_green, input in_blue,
                  input in_alpha, output ready);
endinterface

interface ssbr_out_if;
    import ssbr_pkg::*;

    logic               valid;
    logic               ready;
    logic [CHAN_W-1:0]  out_red;
    logic [CHAN_W-1:0]  out_green;
    logic [CHAN_W-1:0]  out_blue;
    logic [CHAN_W-1:0]  out_alpha;
    logic [COORD_W-1:0] pixel_x;
    logic [COORD_W-1:0] pixel_y;
    logic               row_end;
    logic               frame_end;

    modport source (output valid, output out_red, output out_green, output out_blue,
                    output out_alpha, output pixel_x, output pixel_y, output row_end,
                    output frame_end, input ready);
    modport sink (input valid, input out_red, input out_green, input out_blue,
                  input out_alpha, input pixel_x, input pixel_y, input row_end,
                  input frame_end, output ready);
endinterface

[design/ssbr_ram.sv]
// generic single-write, single-read ram with registered read data
module ssbr_ram #(
    parameter int WIDTH = 14,
    parameter int DEPTH = 1024,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[design/ssbr_seq.sv]
// raster position counters: column, sub-column, sub-row and output row
module ssbr_seq #(
    parameter int MAX_WIDTH  = ssbr_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = ssbr_pkg::DEF_MAX_HEIGHT,
    parameter int MAX_FACTOR = ssbr_pkg::DEF_MAX_FACTOR,
    localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1,
    localparam int RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1,
    localparam int SW = (MAX_FACTOR > 1) ? $clog2(MAX_FACTOR) : 1,
    localparam int FW = $clog2(MAX_FACTOR + 1)
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          step,
    input  logic [ssbr_pkg::FACTOR_W-1:0] factor,
    input  logic [ssbr_pkg::SIZE_W-1:0]   out_width,
    input  logic [ssbr_pkg::SIZE_W-1:0]   out_height,
    output logic [CW-1:0]                 col,
    output logic [RW-1:0]                 row,
    output logic [FW-1:0]                 f_eff,
    output ssbr_pkg::seq_flags_t          flags
);
    import ssbr_pkg::*;

    logic [CW-1:0] column_count_reg, column_count_next;
    logic [SW-1:0] sub_column_reg, sub_column_next;
    logic [SW-1:0] sub_row_reg, sub_row_next;
    logic [RW-1:0] row_count_reg, row_count_next;

    logic [SW-1:0] f_last;
    logic [CW-1:0] w_last;
    logic [RW-1:0] h_last;
    logic          last_sc, last_sr, last_col, last_row;

    // last index of each counter under the current, range-limited registers
    always_comb
    begin
        if (factor == '0)
            f_last = '0;
        else if (int'(factor) > MAX_FACTOR)
            f_last = SW'(MAX_FACTOR - 1);
        else
            f_last = SW'(factor - FACTOR_W'(1));

        if (out_width == '0)
            w_last = '0;
        else if (int'(out_width) > MAX_WIDTH)
            w_last = CW'(MAX_WIDTH - 1);
        else
            w_last = CW'(out_width - SIZE_W'(1));

        if (out_height == '0)
            h_last = '0;
        else if (int'(out_height) > MAX_HEIGHT)
            h_last = RW'(MAX_HEIGHT - 1);
        else
            h_last = RW'(out_height - SIZE_W'(1));
    end

    assign last_sc  = (sub_column_reg >= f_last);
    assign last_sr  = (sub_row_reg >= f_last);
    assign last_col = (column_count_reg >= w_last);
    assign last_row = (row_count_reg >= h_last);

    assign f_eff           = FW'(f_last) + FW'(1);
    assign col             = column_count_reg;
    assign row             = row_count_reg;
    assign flags.first     = (sub_row_reg == '0) && (sub_column_reg == '0);
    assign flags.emit      = last_sc && last_sr;
    assign flags.row_end   = last_col;
    assign flags.frame_end = last_col && last_row;

    // counters wrap once they reach or pass their last value
    always_comb
    begin
        column_count_next = column_count_reg;
        sub_column_next   = sub_column_reg;
        sub_row_next      = sub_row_reg;
        row_count_next    = row_count_reg;
        if (!last_sc)
        begin
            sub_column_next = sub_column_reg + SW'(1);
        end
        else
        begin
            sub_column_next = '0;
            if (!last_col)
            begin
                column_count_next = column_count_reg + CW'(1);
            end
            else
            begin
                column_count_next = '0;
                if (!last_sr)
                begin
                    sub_row_next = sub_row_reg + SW'(1);
                end
                else
                begin
                    sub_row_next   = '0;
                    row_count_next = last_row ? '0 : row_count_reg + RW'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            column_count_reg <= '0;
            sub_column_reg   <= '0;
            sub_row_reg      <= '0;
            row_count_reg    <= '0;
        end
        else if (step)
        begin
            column_count_reg <= column_count_next;
            sub_column_reg   <= sub_column_next;
            sub_row_reg      <= sub_row_next;
            row_count_reg    <= row_count_next;
        end
    end

endmodule

[design/ssbr_lane.sv]
// one channel lane: column-sum accumulate in ram, then divide by factor squared
module ssbr_lane #(
    parameter int SUM_W     = 14,
    parameter int DIV_W     = 7,
    parameter int MAX_WIDTH = ssbr_pkg::DEF_MAX_WIDTH,
    localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  ssbr_pkg::lane_ctl_t         ctl,
    input  logic [AW-1:0]               rd_addr,
    input  logic [AW-1:0]               wr_addr,
    input  logic [ssbr_pkg::CHAN_W-1:0] sample,
    input  logic [SUM_W:0]              recip,
    input  logic [DIV_W-1:0]            divisor,
    output logic [ssbr_pkg::CHAN_W-1:0] avg
);
    import ssbr_pkg::*;

    localparam int PROD_W = 2 * SUM_W + 1;
    localparam int QD_W   = SUM_W + DIV_W;

    logic [CHAN_W-1:0] sample_reg;
    logic [SUM_W-1:0]  ram_q;
    logic [SUM_W-1:0]  base;
    logic [SUM_W-1:0]  sum1;

    logic              fwd_valid_reg;
    logic [AW-1:0]     fwd_addr_reg;
    logic [SUM_W-1:0]  fwd_data_reg;

    logic [SUM_W-1:0]  sum2_reg;
    logic [SUM_W-1:0]  sum3_reg;
    logic [PROD_W-1:0] prod3_reg;
    logic [SUM_W-1:0]  quot3;
    logic [QD_W-1:0]   qd_full;
    logic [SUM_W-1:0]  sum4_reg;
    logic [SUM_W-1:0]  quot4_reg;
    logic [SUM_W-1:0]  qd4_reg;
    logic [SUM_W-1:0]  rem4;
    logic [SUM_W-1:0]  quot_fix;

    ssbr_ram #(
        .WIDTH (SUM_W),
        .DEPTH (MAX_WIDTH)
    ) u_sums (
        .clk   (clk),
        .we    (ctl.wr && ctl.adv),
        .waddr (wr_addr),
        .wdata (sum1),
        .re    (ctl.rd),
        .raddr (rd_addr),
        .rdata (ram_q)
    );

    // the write landing on the same edge as this item's read is not in ram_q yet
    always_comb
    begin
        if (ctl.first)
            base = '0;
        else if (fwd_valid_reg && (fwd_addr_reg == wr_addr))
            base = fwd_data_reg;
        else
            base = ram_q;
        sum1 = base + SUM_W'(sample_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            fwd_valid_reg <= 1'b0;
        else if (ctl.adv)
            fwd_valid_reg <= ctl.wr;
    end

    // floor(sum / d) from the scaled reciprocal, low by at most one
    assign quot3   = prod3_reg[2*SUM_W-1:SUM_W];
    assign qd_full = QD_W'(quot3) * QD_W'(divisor);

    always_ff @(posedge clk)
    begin
        if (ctl.rd)
            sample_reg <= sample;
        if (ctl.adv)
        begin
            fwd_addr_reg <= wr_addr;
            fwd_data_reg <= sum1;
            sum2_reg     <= sum1;
            prod3_reg    <= PROD_W'(sum2_reg) * PROD_W'(recip);
            sum3_reg     <= sum2_reg;
            quot4_reg    <= quot3;
            qd4_reg      <= qd_full[SUM_W-1:0];
            sum4_reg     <= sum3_reg;
        end
    end

    assign rem4     = sum4_reg - qd4_reg;
    assign quot_fix = (rem4 >= SUM_W'(divisor)) ? quot4_reg + SUM_W'(1) : quot4_reg;
    assign avg      = quot_fix[CHAN_W-1:0];

endmodule

[design/supersample_box_resolve_top.sv]
// a block-closing item passes s1 to s4, then its result goes into the output register
// throughput: one item per cycle unless held; each lane's column-sum ram does one
//   read and one write per cycle, with a bypass for back-to-back items on the same
//   column; the whole pipeline holds while a result waits in the output register
// reset clears counters and valid bits and loads factor 1, size 1024 by 1024;
//   column-sum ram contents are not cleared and no clearing pass runs
module supersample_box_resolve_top #(
    parameter int MAX_WIDTH  = ssbr_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = ssbr_pkg::DEF_MAX_HEIGHT,
    parameter int MAX_FACTOR = ssbr_pkg::DEF_MAX_FACTOR
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [ssbr_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [ssbr_pkg::CFG_DATA_W-1:0] cfg_data,
    ssbr_in_if.sink                         px_in,
    ssbr_out_if.source                      px_out
);
    import ssbr_pkg::*;

    localparam int CW    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int RW    = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int FW    = $clog2(MAX_FACTOR + 1);
    localparam int SUM_W = CHAN_W + $clog2(MAX_FACTOR * MAX_FACTOR);
    localparam int DIV_W = $clog2(MAX_FACTOR * MAX_FACTOR + 1);

    logic [FACTOR_W-1:0] factor_reg;
    logic [SIZE_W-1:0]   width_reg;
    logic [SIZE_W-1:0]   height_reg;

    logic                adv;
    logic                acc;
    logic [CW-1:0]       col;
    logic [RW-1:0]       row;
    logic [FW-1:0]       f_eff;
    seq_flags_t          flags;

    logic [SUM_W:0]      recip_tab [MAX_FACTOR+1];
    logic [DIV_W-1:0]    div_tab [MAX_FACTOR+1];
    logic [SUM_W:0]      recip_reg;
    logic [DIV_W-1:0]    div_reg;

    logic                s1_valid_reg;
    logic                s1_emit_reg;
    logic                s1_first_reg;
    logic [CW-1:0]       s1_col_reg;
    meta_t               s1_meta_reg;
    logic                s2_valid_reg, s3_valid_reg, s4_valid_reg;
    meta_t               s2_meta_reg, s3_meta_reg, s4_meta_reg;
    logic                out_valid_reg;
    meta_t               out_meta_reg;
    logic [CHAN_W-1:0]   out_chan_reg [NUM_LANES];

    lane_ctl_t           lane_ctl;
    logic [CHAN_W-1:0]   samples [NUM_LANES];
    logic [CHAN_W-1:0]   avgs [NUM_LANES];

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            factor_reg <= FACTOR_RST;
            width_reg  <= SIZE_RST;
            height_reg <= SIZE_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_FACTOR: factor_reg <= cfg_data[FACTOR_W-1:0];
                CFG_WIDTH:  width_reg  <= cfg_data[SIZE_W-1:0];
                CFG_HEIGHT: height_reg <= cfg_data[SIZE_W-1:0];
                default:    ;
            endcase
        end
    end

    assign adv          = !out_valid_reg || px_out.ready;
    assign acc          = px_in.valid && adv;
    assign px_in.ready  = adv;

    ssbr_seq #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .MAX_FACTOR (MAX_FACTOR)
    ) u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (acc),
        .factor     (factor_reg),
        .out_width  (width_reg),
        .out_height (height_reg),
        .col        (col),
        .row        (row),
        .f_eff      (f_eff),
        .flags      (flags)
    );

    // reciprocal and divisor per factor, worked out at elaboration
    for (genvar g = 0; g <= MAX_FACTOR; g++)
    begin : g_tab
        localparam int G = (g == 0) ? 1 : g;
        localparam longint unsigned RECIP = (64'd1 << SUM_W) / (G * G);
        assign recip_tab[g] = (SUM_W + 1)'(RECIP);
        assign div_tab[g]   = DIV_W'(G * G);
    end

    always_ff @(posedge clk)
    begin
        recip_reg <= recip_tab[f_eff];
        div_reg   <= div_tab[f_eff];
    end

    // pipeline valid bits; only block-closing items travel past stage one
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s1_emit_reg   <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            s4_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg  <= acc;
            s1_emit_reg   <= acc && flags.emit;
            s2_valid_reg  <= s1_emit_reg;
            s3_valid_reg  <= s2_valid_reg;
            s4_valid_reg  <= s3_valid_reg;
            out_valid_reg <= s4_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_first_reg          <= flags.first;
            s1_col_reg            <= col;
            s1_meta_reg.x         <= COORD_W'(col);
            s1_meta_reg.y         <= COORD_W'(row);
            s1_meta_reg.row_end   <= flags.row_end;
            s1_meta_reg.frame_end <= flags.frame_end;
            s2_meta_reg           <= s1_meta_reg;
            s3_meta_reg           <= s2_meta_reg;
            s4_meta_reg           <= s3_meta_reg;
            out_meta_reg          <= s4_meta_reg;
            for (int i = 0; i < NUM_LANES; i++)
            begin
                out_chan_reg[i] <= avgs[i];
            end
        end
    end

    assign lane_ctl.adv   = adv;
    assign lane_ctl.rd    = acc;
    assign lane_ctl.wr    = s1_valid_reg;
    assign lane_ctl.first = s1_first_reg;

    assign samples[0] = px_in.in_red;
    assign samples[1] = px_in.in_green;
    assign samples[2] = px_in.in_blue;
    assign samples[3] = px_in.in_alpha;

    for (genvar l = 0; l < NUM_LANES; l++)
    begin : g_lane
        ssbr_lane #(
            .SUM_W     (SUM_W),
            .DIV_W     (DIV_W),
            .MAX_WIDTH (MAX_WIDTH)
        ) u_lane (
            .clk     (clk),
            .rst_n   (rst_n),
            .ctl     (lane_ctl),
            .rd_addr (col),
            .wr_addr (s1_col_reg),
            .sample  (samples[l]),
            .recip   (recip_reg),
            .divisor (div_reg),
            .avg     (avgs[l])
        );
    end

    assign px_out.valid     = out_valid_reg;
    assign px_out.out_red   = out_chan_reg[0];
    assign px_out.out_green = out_chan_reg[1];
    assign px_out.out_blue  = out_chan_reg[2];
    assign px_out.out_alpha = out_chan_reg[3];
    assign px_out.pixel_x   = out_meta_reg.x;
    assign px_out.pixel_y   = out_meta_reg.y;
    assign px_out.row_end   = out_meta_reg.row_end;
    assign px_out.frame_end = out_meta_reg.frame_end;

endmodule

[design/ssbr_chk.sv]
// port-level checks for the resolve block, bound to the top level
module ssbr_chk (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        in_ready,
    input logic                        out_valid,
    input logic                        out_ready,
    input logic [ssbr_pkg::CHAN_W-1:0]  out_red,
    input logic [ssbr_pkg::COORD_W-1:0] pixel_x,
    input logic [ssbr_pkg::COORD_W-1:0] pixel_y,
    input logic                        row_end,
    input logic                        frame_end
);

    // a waiting result holds still
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_red)
            && $stable(pixel_x) && $stable(pixel_y))
        else $error("result changed while stalled");

    // the last pixel of the frame also closes its row
    a_frame_row: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !frame_end || row_end)
        else $error("frame end without row end");

    // an empty output register never blocks the input
    a_ready_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled with empty output");

    // a result being taken frees the pipeline for a new item
    a_ready_take: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready |-> in_ready)
        else $error("input stalled while result taken");

endmodule

bind supersample_box_resolve_top ssbr_chk u_ssbr_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ready  (px_in.ready),
    .out_valid (px_out.valid),
    .out_ready (px_out.ready),
    .out_red   (px_out.out_red),
    .pixel_x   (px_out.pixel_x),
    .pixel_y   (px_out.pixel_y),
    .row_end   (px_out.row_end),
    .frame_end (px_out.frame_end)
);

[verif/ssbr_resolve_check.sv]
// checker: predicts resolved pixels from accepted samples and compares them with the block output
module ssbr_resolve_check (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [ssbr_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [ssbr_pkg::CFG_DATA_W-1:0] cfg_data,
    ssbr_in_if                              px_in,
    ssbr_out_if                             px_out,
    input  logic                            end_check,
    output int                              fail_count,
    output int                              pending,
    output int                              safe_width,
    output int                              items_seen,
    output int                              pixels_resolved,
    output int                              frames_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    import ssbr_pkg::*;

    localparam int COLS        = DEF_MAX_WIDTH;
    localparam int ROWS        = DEF_MAX_HEIGHT;
    localparam int FMAX        = DEF_MAX_FACTOR;
    localparam int SUB_W       = $clog2(FMAX);
    localparam int MAX_REPORTS = 40;

    typedef struct packed {
        logic [CHAN_W-1:0]  red;
        logic [CHAN_W-1:0]  green;
        logic [CHAN_W-1:0]  blue;
        logic [CHAN_W-1:0]  alpha;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic               row_end;
        logic               frame_end;
    } resolved_px_t;

    logic [FACTOR_W-1:0] factor_reg;
    logic [SIZE_W-1:0]   width_reg;
    logic [SIZE_W-1:0]   height_reg;

    int unsigned         col_sum [COLS][NUM_LANES];
    bit                  col_written [COLS];
    int                  lead_written;
    logic [COORD_W-1:0]  col_pos;
    logic [COORD_W-1:0]  row_pos;
    logic [SUB_W-1:0]    sub_col;
    logic [SUB_W-1:0]    sub_row;

    resolved_px_t        expected_px [$];
    int                  mismatches;
    int                  n_items;
    int                  n_results;
    int                  n_frames;
    bit                  leftover_flagged;

    function automatic int unsigned fit_range(input int unsigned v, input int unsigned hi);
        if (v == 0)
            return 1;
        if (v > hi)
            return hi;
        return v;
    endfunction

    task automatic report_mismatch(input string msg);
        if (mismatches < MAX_REPORTS)
            $display("[%0t] resolve mismatch: %s", $time, msg);
        mismatches++;
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %0d, expected %0d", name, got, want));
    endtask

    task automatic accumulate_sample(input logic [NUM_LANES-1:0][CHAN_W-1:0] ch);
        int unsigned  f;
        int unsigned  w;
        int unsigned  h;
        int unsigned  div;
        int           c;
        int           k;
        bit           last_sc;
        bit           last_sr;
        bit           last_col;
        bit           last_row;
        resolved_px_t px;
        f = fit_range(32'(factor_reg), FMAX);
        w = fit_range(32'(width_reg), COLS);
        h = fit_range(32'(height_reg), ROWS);
        c = int'(col_pos);

        // first sample of a block replaces the column sum
        for (k = 0; k < NUM_LANES; k++) begin
            if (sub_row == 0 && sub_col == 0)
                col_sum[c][k] = 32'(ch[k]);
            else
                col_sum[c][k] += 32'(ch[k]);
        end
        col_written[c] = 1'b1;
        while (lead_written < COLS && col_written[lead_written])
            lead_written++;

        last_sc  = sub_col >= f - 1;
        last_sr  = sub_row >= f - 1;
        last_col = c >= w - 1;
        last_row = row_pos >= h - 1;

        if (last_sc && last_sr) begin
            div          = f * f;
            px.red       = CHAN_W'(col_sum[c][0] / div);
            px.green     = CHAN_W'(col_sum[c][1] / div);
            px.blue      = CHAN_W'(col_sum[c][2] / div);
            px.alpha     = CHAN_W'(col_sum[c][3] / div);
            px.x         = COORD_W'(c);
            px.y         = row_pos;
            px.row_end   = last_col;
            px.frame_end = last_col && last_row;
            expected_px.push_back(px);
        end

        // counters wrap as soon as they reach or pass the last value of the current setting
        if (!last_sc) begin
            sub_col++;
        end
        else begin
            sub_col = '0;
            if (!last_col) begin
                col_pos++;
            end
            else begin
                col_pos = '0;
                if (!last_sr) begin
                    sub_row++;
                end
                else begin
                    sub_row = '0;
                    row_pos = last_row ? '0 : row_pos + 1'b1;
                end
            end
        end
    endtask

    task automatic check_result();
        resolved_px_t want;
        if (expected_px.size() == 0) begin
            report_mismatch($sformatf("result at x=%0d y=%0d with nothing expected",
                                      px_out.pixel_x, px_out.pixel_y));
            return;
        end
        want = expected_px.pop_front();
        check_field("out_red", 32'(px_out.out_red), 32'(want.red));
        check_field("out_green", 32'(px_out.out_green), 32'(want.green));
        check_field("out_blue", 32'(px_out.out_blue), 32'(want.blue));
        check_field("out_alpha", 32'(px_out.out_alpha), 32'(want.alpha));
        check_field("pixel_x", 32'(px_out.pixel_x), 32'(want.x));
        check_field("pixel_y", 32'(px_out.pixel_y), 32'(want.y));
        check_field("row_end", 32'(px_out.row_end), 32'(want.row_end));
        check_field("frame_end", 32'(px_out.frame_end), 32'(want.frame_end));
        n_results++;
        if (want.frame_end)
            n_frames++;
    endtask

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            factor_reg   = FACTOR_RST;
            width_reg    = SIZE_RST;
            height_reg   = SIZE_RST;
            col_pos      = '0;
            row_pos      = '0;
            sub_col      = '0;
            sub_row      = '0;
            lead_written = 0;
            foreach (col_written[i])
                col_written[i] = 1'b0;
            expected_px.delete();
            pending    <= 0;
            safe_width <= COLS;
        end
        else begin
            if (px_out.valid && px_out.ready)
                check_result();
            if (cfg_we) begin
                case (cfg_idx_t'(cfg_index))
                    CFG_FACTOR: factor_reg = cfg_data[FACTOR_W-1:0];
                    CFG_WIDTH:  width_reg  = cfg_data[SIZE_W-1:0];
                    CFG_HEIGHT: height_reg = cfg_data[SIZE_W-1:0];
                    default: ;
                endcase
            end
            if (px_in.valid && px_in.ready) begin
                accumulate_sample({px_in.in_alpha, px_in.in_blue, px_in.in_green,
                                   px_in.in_red});
                n_items++;
            end
            if (end_check && !leftover_flagged && expected_px.size() != 0) begin
                report_mismatch($sformatf("%0d resolved pixels never came out",
                                          expected_px.size()));
                leftover_flagged = 1'b1;
            end
            pending         <= expected_px.size();
            // inside a block row only columns already holding a sum may come into range
            safe_width      <= (sub_row == 0) ? COLS : lead_written;
            fail_count      <= mismatches;
            items_seen      <= n_items;
            pixels_resolved <= n_results;
            frames_seen     <= n_frames;
        end
    end

endmodule

[verif/tb_top.sv]
// top of the supersample box resolve testbench: clock, reset, stimulus, verdict
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import ssbr_pkg::*;

    localparam int SETTLE_CYCLES  = 10;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int HOLD_CYCLES    = 300;
    localparam int RANDOM_ITEMS   = 640;
    localparam int WIDEST         = DEF_MAX_WIDTH;

    logic                  clk   = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_we;
    cfg_idx_t              cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  end_check;

    int send_idle_pct;
    int stall_pct;
    int hold_len;
    bit hold_req;
    bit hold_ack;
    int hold_left;
    int n_settings;
    int quiet_cycles;
    int phase;

    int fail_count;
    int pending;
    int safe_width;
    int items_seen;
    int pixels_resolved;
    int frames_seen;

    ssbr_in_if  px_in ();
    ssbr_out_if px_out ();

    supersample_box_resolve_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .px_in     (px_in),
        .px_out    (px_out)
    );

    ssbr_resolve_check u_resolve_check (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .px_in           (px_in),
        .px_out          (px_out),
        .end_check       (end_check),
        .fail_count      (fail_count),
        .pending         (pending),
        .safe_width      (safe_width),
        .items_seen      (items_seen),
        .pixels_resolved (pixels_resolved),
        .frames_seen     (frames_seen)
    );

    always #5ns clk = ~clk;

    // receiver: random stalls, plus a long hold-off on request
    initial
    begin
        px_out.ready = 1'b0;
        hold_ack     = 1'b0;
        hold_left    = 0;
        forever
        begin
            @(posedge clk);
            if (hold_req != hold_ack)
            begin
                hold_left = hold_len;
                hold_ack  = hold_req;
            end
            if (hold_left > 0)
            begin
                px_out.ready <= 1'b0;
                hold_left--;
            end
            else
                px_out.ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (px_in.valid && px_in.ready) || (px_out.valid && px_out.ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog: no item moved for %0d cycles", WATCHDOG_LIMIT);
            $display("*** FAILED ***");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    function automatic logic [CHAN_W-1:0] rand_chan();
        case ($urandom_range(9))
            0:       return '0;
            1:       return '1;
            default: return CHAN_W'($urandom_range(255));
        endcase
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_factor();
        case ($urandom_range(9))
            0:       return '0;
            // upper data bits are ignored; low nibble may exceed the factor limit
            1:       return CFG_DATA_W'($urandom_range(2047, 9));
            2, 3:    return CFG_DATA_W'($urandom_range(8, 5));
            default: return CFG_DATA_W'($urandom_range(4, 1));
        endcase
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_size(input int typical);
        case ($urandom_range(15))
            0:       return '0;
            1:       return '1;
            2:       return CFG_DATA_W'($urandom_range(2047, 1025));
            3:       return CFG_DATA_W'($urandom_range(1024, 1));
            default: return CFG_DATA_W'($urandom_range(typical, 1));
        endcase
    endfunction

    task automatic set_idling(input int mode);
        case (mode)
            0:
            begin
                send_idle_pct = 0;
                stall_pct    <= 0;
            end
            1:
            begin
                send_idle_pct = 72;
                stall_pct    <= 0;
            end
            2:
            begin
                send_idle_pct = 0;
                stall_pct    <= 72;
            end
            default:
            begin
                send_idle_pct = 6;
                stall_pct    <= 6;
            end
        endcase
    endtask

    task automatic send_pixel(input logic [CHAN_W-1:0] r, g, b, a);
        while ($urandom_range(99) < send_idle_pct)
        begin
            px_in.valid <= 1'b0;
            @(posedge clk);
        end
        px_in.valid    <= 1'b1;
        px_in.in_red   <= r;
        px_in.in_green <= g;
        px_in.in_blue  <= b;
        px_in.in_alpha <= a;
        @(posedge clk);
        while (!px_in.ready)
            @(posedge clk);
    endtask

    task automatic send_random(input int n);
        repeat (n)
            send_pixel(rand_chan(), rand_chan(), rand_chan(), rand_chan());
    endtask

    // stop offering, let every expected pixel come out, then let the pipeline settle
    task automatic wait_idle();
        px_in.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES)
            @(posedge clk);
    endtask

    task automatic write_regs(input logic [CFG_DATA_W-1:0] f, w, h);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_FACTOR;
        cfg_data  <= f;
        @(posedge clk);
        cfg_index <= CFG_WIDTH;
        cfg_data  <= w;
        @(posedge clk);
        cfg_index <= CFG_HEIGHT;
        cfg_data  <= h;
        @(posedge clk);
        cfg_we    <= 1'b0;
        n_settings++;
    endtask

    initial
    begin
        logic [CFG_DATA_W-1:0] f_val;
        logic [CFG_DATA_W-1:0] w_val;
        logic [CFG_DATA_W-1:0] h_val;
        int                    k;

        px_in.valid    = 1'b0;
        px_in.in_red   = '0;
        px_in.in_green = '0;
        px_in.in_blue  = '0;
        px_in.in_alpha = '0;
        cfg_we         = 1'b0;
        cfg_index      = CFG_FACTOR;
        cfg_data       = '0;
        end_check      = 1'b0;
        hold_len       = 0;
        hold_req       = 1'b0;
        stall_pct      = 0;
        send_idle_pct  = 0;
        n_settings     = 0;
        phase          = 0;

        repeat (9)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset setting: factor 1 on a 1024 wide image, so every sample is a pixel
        send_pixel('0, '0, '0, '0);
        send_pixel('1, '1, '1, '1);
        send_pixel(8'h55, 8'hAA, 8'h55, 8'hAA);
        send_pixel(8'hAA, 8'h55, 8'hAA, 8'h55);
        send_pixel(8'hFF, 8'h00, 8'h80, 8'h01);

        // zero factor and sizes behave as one, and the counters wrap mid row
        wait_idle();
        write_regs('0, '0, '0);
        send_pixel(8'h12, 8'h34, 8'h56, 8'h78);
        send_pixel(8'h9A, 8'hBC, 8'hDE, 8'hF0);

        // 2x2 blocks whose averages need flooring
        wait_idle();
        write_regs(11'd2, 11'd2, 11'd1);
        for (k = 0; k < 8; k++)
            send_pixel(CHAN_W'(k * 37), CHAN_W'(255 - k), k[0] ? 8'hFF : 8'h00, 8'd3);

        // factor 3: division by nine
        wait_idle();
        write_regs(11'd3, 11'd1, 11'd1);
        for (k = 0; k < 9; k++)
            send_pixel((k == 4) ? 8'd201 : 8'd200, 8'd1, 8'd254, CHAN_W'(k));

        while (items_seen < RANDOM_ITEMS + 24)
        begin
            wait_idle();
            f_val = pick_factor();
            w_val = pick_size(6);
            h_val = pick_size(4);
            if (phase == 1)
                f_val = CFG_DATA_W'(1);
            // a wider image inside a block row must not reach columns with no sum yet
            if (safe_width != WIDEST && w_val > safe_width)
                w_val = CFG_DATA_W'(safe_width);
            write_regs(f_val, w_val, h_val);
            if (phase == 1)
            begin
                // long receiver hold-off while samples keep coming: the block backs up
                set_idling(0);
                hold_len <= HOLD_CYCLES;
                hold_req <= ~hold_req;
                send_random(120);
            end
            else
            begin
                set_idling(phase % 4);
                send_random($urandom_range(80, 20));
            end
            phase++;
        end

        // largest blocks at full scale give the largest sums
        wait_idle();
        write_regs(11'd8, 11'd2, 11'd1);
        set_idling(3);
        repeat (128)
            send_pixel('1, '1, '1, '1);

        wait_idle();
        end_check <= 1'b1;
        repeat (2)
            @(posedge clk);

        $display("run: %0d samples in, %0d pixels resolved, %0d frames closed",
                 items_seen, pixels_resolved, frames_seen);
        $display("run: %0d register settings incl. factor 1..8, out-of-range values, sizes to 1024",
                 n_settings);
        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

[sim.f]
design/ssbr_pkg.sv
design/ssbr_if.sv
design/ssbr_ram.sv
design/ssbr_seq.sv
design/ssbr_lane.sv
design/supersample_box_resolve_top.sv
design/ssbr_chk.sv
verif/ssbr_resolve_check.sv
verif/tb_top.sv
